// ----- sv/baro_height_smoother_macros.svh -----
// ----------------------------------------------------------------------------
// Barometric height smoother assertion macros
// Shared concurrent assertion forms; compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef BARO_HEIGHT_SMOOTHER_MACROS_SVH
`define BARO_HEIGHT_SMOOTHER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is held
`define BHS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held
`define BHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BHS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BHS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/bhs_pkg.sv -----
// ----------------------------------------------------------------------------
// Barometric height smoother package
// Widths, constants, control word types and the microprogram ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package bhs_pkg;

    // Field and datapath widths
    localparam int RAW_W      = 24;
    localparam int AVG_W      = 32;
    localparam int PRESS_W    = 27;
    localparam int FACTOR_W   = 40;
    localparam int DIFF_W     = 33;
    localparam int MUL_A_W    = 33;
    localparam int MUL_B_W    = 27;
    localparam int MUL_W      = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = 60;
    localparam int HEIGHT_W   = 32;
    localparam int COUNT_W    = 3;
    localparam int TEMP_FRAC  = 8;
    localparam int FRAC_LO_W  = 20;
    localparam int DP_SHIFT   = 4;
    localparam int ROUND_SHIFT = 12;

    // Warm-up length before the baseline is latched
    localparam logic [COUNT_W-1:0] WARMUP_SAMPLES = 3'd5;

    // Pressure conversion in Q40, rounded half up to Q16
    localparam int Q40_W      = 52;
    localparam int CONV_SHIFT = 24;
    localparam logic [Q40_W-1:0]   P0_Q40    = 52'd1501163225402573;
    localparam logic [MUL_B_W-1:0] SLOPE_Q40 = 27'd83074212;

    // Height rounding and saturation
    localparam logic signed [ACC_W-1:0] ACC_ROUND = ACC_W'(1) <<< (ROUND_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] H_MAX = (ACC_W'(1) <<< (HEIGHT_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] H_MIN = -(ACC_W'(1) <<< (HEIGHT_W - 1));

    // Divide-by-five unit: radix-16 digits, several digits per pass
    localparam int DIV_W           = 36;
    localparam int DIGIT_W         = 4;
    localparam int REM_W           = 3;
    localparam int DIGITS_PER_PASS = 3;
    localparam int PASS_W          = DIGIT_W * DIGITS_PER_PASS;
    localparam int DIV_PASSES      = DIV_W / PASS_W;
    localparam int DIV_CNT_W       = $clog2(DIV_PASSES + 1);
    localparam int V_W             = DIGIT_W + REM_W;
    localparam int DIVISOR         = 5;
    localparam int RECIP_W         = 15;
    localparam int RECIP           = 205;
    localparam int RECIP_SHIFT     = 10;

    // Microprogram addresses
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE   = 4'd0;
    localparam step_t STEP_MUL_P  = 4'd1;
    localparam step_t STEP_CONV_P = 4'd2;
    localparam step_t STEP_WAIT_T = 4'd3;
    localparam step_t STEP_WAIT_P = 4'd4;
    localparam step_t STEP_WARMUP = 4'd5;
    localparam step_t STEP_CHECK  = 4'd6;
    localparam step_t STEP_MUL_LO = 4'd7;
    localparam step_t STEP_MUL_HI = 4'd8;
    localparam step_t STEP_MAG    = 4'd9;
    localparam step_t STEP_SUM    = 4'd10;
    localparam step_t STEP_SCALE  = 4'd11;
    localparam step_t STEP_SAT    = 4'd12;
    localparam step_t STEP_OUT    = 4'd13;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_NO_INPUT,
        COND_DIV_BUSY,
        COND_NOT_READY,
        COND_OUT_BUSY
    } cond_t;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_PRESS,
        MUL_LO,
        MUL_HI
    } mul_op_t;

    typedef enum logic [1:0] {
        DIV_NONE,
        DIV_TEMP,
        DIV_PRESS
    } div_op_t;

    typedef enum logic [3:0] {
        ALU_NONE,
        ALU_LOAD_IN,
        ALU_CONV_P,
        ALU_LATCH_QT,
        ALU_UPDATE_AVG,
        ALU_WARMUP,
        ALU_DIFF,
        ALU_ACC_SHIFT,
        ALU_MAG,
        ALU_SUM,
        ALU_SCALE,
        ALU_SAT,
        ALU_OUTPUT
    } alu_op_t;

    typedef struct packed {
        cond_t   cond;
        step_t   target;
        logic    last;
        mul_op_t mul;
        div_op_t div;
        alu_op_t alu;
    } ucode_t;

    // Sequencer to datapath
    typedef struct packed {
        logic    exec;
        mul_op_t mul;
        div_op_t div;
        alu_op_t alu;
    } ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic div_busy;
        logic baseline_ready;
        logic out_busy;
    } status_t;

    // One quotient digit of a value below 80 divided by five
    function automatic logic [DIGIT_W-1:0] div5_digit(input logic [V_W-1:0] v);
        logic [RECIP_W-1:0] p;
        p = RECIP_W'(v) * RECIP_W'(RECIP);
        return p[RECIP_SHIFT +: DIGIT_W];
    endfunction

    // Microprogram ROM; a taken jump suppresses the step's datapath action
    function automatic ucode_t ucode_word(input step_t pc);
        ucode_t w;
        w = '{cond: COND_NEVER, target: STEP_IDLE, last: 1'b0,
              mul: MUL_NONE, div: DIV_NONE, alu: ALU_NONE};
        unique case (pc)
            STEP_IDLE: begin
                w.cond   = COND_NO_INPUT;
                w.target = STEP_IDLE;
                w.alu    = ALU_LOAD_IN;
            end
            STEP_MUL_P: begin
                w.mul = MUL_PRESS;
                w.div = DIV_TEMP;
            end
            STEP_CONV_P: begin
                w.alu = ALU_CONV_P;
            end
            STEP_WAIT_T: begin
                w.cond   = COND_DIV_BUSY;
                w.target = STEP_WAIT_T;
                w.alu    = ALU_LATCH_QT;
                w.div    = DIV_PRESS;
            end
            STEP_WAIT_P: begin
                w.cond   = COND_DIV_BUSY;
                w.target = STEP_WAIT_P;
                w.alu    = ALU_UPDATE_AVG;
            end
            STEP_WARMUP: begin
                w.alu = ALU_WARMUP;
            end
            STEP_CHECK: begin
                w.cond   = COND_NOT_READY;
                w.target = STEP_OUT;
                w.alu    = ALU_DIFF;
            end
            STEP_MUL_LO: begin
                w.mul = MUL_LO;
            end
            STEP_MUL_HI: begin
                w.mul = MUL_HI;
                w.alu = ALU_ACC_SHIFT;
            end
            STEP_MAG: begin
                w.alu = ALU_MAG;
            end
            STEP_SUM: begin
                w.alu = ALU_SUM;
            end
            STEP_SCALE: begin
                w.alu = ALU_SCALE;
            end
            STEP_SAT: begin
                w.alu = ALU_SAT;
            end
            STEP_OUT: begin
                w.cond   = COND_OUT_BUSY;
                w.target = STEP_OUT;
                w.last   = 1'b1;
                w.alu    = ALU_OUTPUT;
            end
            default: begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- sv/bhs_div5.sv -----
// ----------------------------------------------------------------------------
// Divide-by-five unit
// Iterative radix-16 long division, several digits per pass, floor quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module bhs_div5 (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [bhs_pkg::DIV_W-1:0]  dividend,
    output logic                            busy,
    output logic [bhs_pkg::DIV_W-1:0]       quotient
);

    localparam int DIV_W   = bhs_pkg::DIV_W;
    localparam int DIGIT_W = bhs_pkg::DIGIT_W;
    localparam int REM_W   = bhs_pkg::REM_W;
    localparam int PASS_W  = bhs_pkg::PASS_W;
    localparam int V_W     = bhs_pkg::V_W;
    localparam int CNT_W   = bhs_pkg::DIV_CNT_W;

    logic [DIV_W-1:0] work_reg, work_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Take one pass of digits off the top of the working word
    always_comb begin
        logic [REM_W-1:0]   r;
        logic [V_W-1:0]     v;
        logic [DIGIT_W-1:0] q;
        logic [PASS_W-1:0]  qbits;
        r     = rem_reg;
        v     = '0;
        q     = '0;
        qbits = '0;
        for (int i = 0; i < bhs_pkg::DIGITS_PER_PASS; i++) begin
            v = {r, work_reg[DIV_W-1-i*DIGIT_W -: DIGIT_W]};
            q = bhs_pkg::div5_digit(v);
            r = REM_W'(v - V_W'(q) * V_W'(bhs_pkg::DIVISOR));
            qbits[PASS_W-1-i*DIGIT_W -: DIGIT_W] = q;
        end

        work_next = work_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            work_next = dividend;
            quo_next  = '0;
            rem_next  = '0;
            cnt_next  = CNT_W'(bhs_pkg::DIV_PASSES);
        end else if (cnt_reg != '0) begin
            work_next = work_reg << PASS_W;
            quo_next  = {quo_reg[DIV_W-PASS_W-1:0], qbits};
            rem_next  = r;
            cnt_next  = cnt_reg - CNT_W'(1);
        end
    end

    // Hold the pass counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Advance the working registers
    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- sv/bhs_sequencer.sv -----
// ----------------------------------------------------------------------------
// Microprogram sequencer
// Step counter over the control ROM with conditional jumps on datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

module bhs_sequencer (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire bhs_pkg::status_t status,
    output logic                  s_ready,
    output bhs_pkg::ctrl_t        ctrl
);

    bhs_pkg::step_t  pc_reg, pc_next;
    bhs_pkg::ucode_t word;
    logic            jump;

    // Fetch the control word and resolve the jump condition
    always_comb begin
        word = bhs_pkg::ucode_word(pc_reg);
        unique case (word.cond)
            bhs_pkg::COND_NEVER:     jump = 1'b0;
            bhs_pkg::COND_NO_INPUT:  jump = !s_valid;
            bhs_pkg::COND_DIV_BUSY:  jump = status.div_busy;
            bhs_pkg::COND_NOT_READY: jump = !status.baseline_ready;
            bhs_pkg::COND_OUT_BUSY:  jump = status.out_busy;
            default:                 jump = 1'b0;
        endcase

        if (jump) begin
            pc_next = word.target;
        end else if (word.last) begin
            pc_next = bhs_pkg::STEP_IDLE;
        end else begin
            pc_next = pc_reg + bhs_pkg::step_t'(1);
        end

        ctrl.exec = !jump;
        ctrl.mul  = word.mul;
        ctrl.div  = word.div;
        ctrl.alu  = word.alu;
    end

    // Hold the step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= bhs_pkg::STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign s_ready = (pc_reg == bhs_pkg::STEP_IDLE);

endmodule

`default_nettype wire

// ----- sv/bhs_datapath.sv -----
// ----------------------------------------------------------------------------
// Smoother datapath
// Averages, baseline, shared multiplier, height arithmetic and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "baro_height_smoother_macros.svh"

module bhs_datapath (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire bhs_pkg::ctrl_t                        ctrl,
    input  wire logic [bhs_pkg::RAW_W-1:0]             s_raw_temperature,
    input  wire logic [bhs_pkg::RAW_W-1:0]             s_raw_pressure,
    input  wire logic                                  cfg_we,
    input  wire logic signed [bhs_pkg::FACTOR_W-1:0]   cfg_wdata,
    input  wire logic                                  m_ready,
    output logic                                       m_valid,
    output logic [bhs_pkg::AVG_W-1:0]                  m_smooth_temperature,
    output logic signed [bhs_pkg::AVG_W-1:0]           m_smooth_pressure,
    output logic signed [bhs_pkg::HEIGHT_W-1:0]        m_height_change,
    output logic                                       m_baseline_ready,
    output bhs_pkg::status_t                           status
);

    localparam int RAW_W    = bhs_pkg::RAW_W;
    localparam int AVG_W    = bhs_pkg::AVG_W;
    localparam int PRESS_W  = bhs_pkg::PRESS_W;
    localparam int FACTOR_W = bhs_pkg::FACTOR_W;
    localparam int DIFF_W   = bhs_pkg::DIFF_W;
    localparam int MUL_A_W  = bhs_pkg::MUL_A_W;
    localparam int MUL_B_W  = bhs_pkg::MUL_B_W;
    localparam int MUL_W    = bhs_pkg::MUL_W;
    localparam int ACC_W    = bhs_pkg::ACC_W;
    localparam int HEIGHT_W = bhs_pkg::HEIGHT_W;
    localparam int COUNT_W  = bhs_pkg::COUNT_W;
    localparam int DIV_W    = bhs_pkg::DIV_W;
    localparam int Q40_W    = bhs_pkg::Q40_W;
    localparam int LO_W     = bhs_pkg::FRAC_LO_W;
    localparam int TFRAC    = bhs_pkg::TEMP_FRAC;

    // Control state
    logic                        have_reg, have_next;
    logic [COUNT_W-1:0]          count_reg, count_next;
    logic signed [FACTOR_W-1:0]  factor_reg, factor_next;
    logic [AVG_W-1:0]            avg_t_reg, avg_t_next;
    logic [AVG_W-1:0]            avg_p_reg, avg_p_next;
    logic [AVG_W-1:0]            base_t_reg, base_t_next;
    logic [AVG_W-1:0]            base_p_reg, base_p_next;
    logic                        m_valid_reg, m_valid_next;

    // Working registers
    logic [RAW_W-1:0]            raw_t_reg, raw_t_next;
    logic [RAW_W-1:0]            raw_p_reg, raw_p_next;
    logic [PRESS_W-1:0]          xp_reg, xp_next;
    logic [AVG_W-1:0]            qt_reg, qt_next;
    logic [DIFF_W-1:0]           ma_reg, ma_next;
    logic [FACTOR_W-1:0]         mf_reg, mf_next;
    logic                        neg_reg, neg_next;
    logic signed [DIFF_W-1:0]    dp_reg, dp_next;
    logic [MUL_W-1:0]            mul_reg, mul_next;
    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    logic signed [HEIGHT_W-1:0]  h_reg, h_next;

    // Output register
    logic [AVG_W-1:0]            out_t_reg, out_t_next;
    logic [AVG_W-1:0]            out_p_reg, out_p_next;
    logic [HEIGHT_W-1:0]         out_h_reg, out_h_next;
    logic                        out_rdy_reg, out_rdy_next;

    // Multiplier operands and divider hookup
    logic [MUL_A_W-1:0]          mul_a;
    logic [MUL_B_W-1:0]          mul_b;
    logic                        div_start;
    logic [DIV_W-1:0]            div_dividend;
    logic                        div_busy;
    logic [DIV_W-1:0]            div_q;
    logic                        ready;

    assign ready = (count_reg >= bhs_pkg::WARMUP_SAMPLES);

    bhs_div5 u_div5 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // Select multiplier operands
    always_comb begin
        unique case (ctrl.mul)
            bhs_pkg::MUL_PRESS: begin
                mul_a = MUL_A_W'(raw_p_reg);
                mul_b = bhs_pkg::SLOPE_Q40;
            end
            bhs_pkg::MUL_LO: begin
                mul_a = ma_reg;
                mul_b = MUL_B_W'(mf_reg[LO_W-1:0]);
            end
            bhs_pkg::MUL_HI: begin
                mul_a = ma_reg;
                mul_b = MUL_B_W'(mf_reg[FACTOR_W-1:LO_W]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_next = mul_reg;
        if (ctrl.exec && (ctrl.mul != bhs_pkg::MUL_NONE)) begin
            mul_next = MUL_W'(mul_a) * MUL_W'(mul_b);
        end
    end

    // Form the divider sum: new sample plus four times the running average, plus two for rounding
    always_comb begin
        unique case (ctrl.div)
            bhs_pkg::DIV_TEMP: begin
                div_dividend = DIV_W'({raw_t_reg, TFRAC'(0)}) + DIV_W'({avg_t_reg, 2'b00})
                             + DIV_W'(2);
            end
            bhs_pkg::DIV_PRESS: begin
                div_dividend = DIV_W'(xp_reg) + DIV_W'({avg_p_reg, 2'b00}) + DIV_W'(2);
            end
            default: begin
                div_dividend = '0;
            end
        endcase
        div_start = ctrl.exec && (ctrl.div != bhs_pkg::DIV_NONE);
    end

    // Decode the step action
    always_comb begin
        logic [Q40_W-1:0]         q40;
        logic signed [DIFF_W-1:0] dt;
        logic signed [ACC_W-1:0]  term;
        logic signed [ACC_W-1:0]  sh;
        q40  = bhs_pkg::P0_Q40 - mul_reg[Q40_W-1:0]
             + (Q40_W'(1) << (bhs_pkg::CONV_SHIFT - 1));
        dt   = $signed({1'b0, avg_t_reg}) - $signed({1'b0, base_t_reg});
        term = neg_reg ? -acc_reg : acc_reg;
        sh   = acc_reg >>> bhs_pkg::ROUND_SHIFT;

        have_next    = have_reg;
        count_next   = count_reg;
        factor_next  = factor_reg;
        avg_t_next   = avg_t_reg;
        avg_p_next   = avg_p_reg;
        base_t_next  = base_t_reg;
        base_p_next  = base_p_reg;
        raw_t_next   = raw_t_reg;
        raw_p_next   = raw_p_reg;
        xp_next      = xp_reg;
        qt_next      = qt_reg;
        ma_next      = ma_reg;
        mf_next      = mf_reg;
        neg_next     = neg_reg;
        dp_next      = dp_reg;
        acc_next     = acc_reg;
        h_next       = h_reg;
        out_t_next   = out_t_reg;
        out_p_next   = out_p_reg;
        out_h_next   = out_h_reg;
        out_rdy_next = out_rdy_reg;
        m_valid_next = m_valid_reg && !m_ready;

        if (cfg_we) begin
            factor_next = cfg_wdata;
        end

        if (ctrl.exec) begin
            unique case (ctrl.alu)
                bhs_pkg::ALU_LOAD_IN: begin
                    raw_t_next = s_raw_temperature;
                    raw_p_next = s_raw_pressure;
                end
                bhs_pkg::ALU_CONV_P: begin
                    xp_next = q40[bhs_pkg::CONV_SHIFT +: PRESS_W];
                end
                bhs_pkg::ALU_LATCH_QT: begin
                    qt_next = div_q[AVG_W-1:0];
                end
                bhs_pkg::ALU_UPDATE_AVG: begin
                    if (have_reg) begin
                        avg_t_next = qt_reg;
                        avg_p_next = div_q[AVG_W-1:0];
                    end else begin
                        avg_t_next = {raw_t_reg, TFRAC'(0)};
                        avg_p_next = AVG_W'(xp_reg);
                    end
                    have_next = 1'b1;
                end
                bhs_pkg::ALU_WARMUP: begin
                    if (count_reg < bhs_pkg::WARMUP_SAMPLES) begin
                        count_next = count_reg + COUNT_W'(1);
                        if ((count_reg + COUNT_W'(1)) >= bhs_pkg::WARMUP_SAMPLES) begin
                            base_t_next = avg_t_reg;
                            base_p_next = avg_p_reg;
                        end
                    end
                end
                bhs_pkg::ALU_DIFF: begin
                    ma_next  = dt[DIFF_W-1] ? DIFF_W'(-dt) : DIFF_W'(dt);
                    mf_next  = factor_reg[FACTOR_W-1] ? FACTOR_W'(-factor_reg)
                                                      : FACTOR_W'(factor_reg);
                    neg_next = dt[DIFF_W-1] ^ factor_reg[FACTOR_W-1];
                    dp_next  = $signed({avg_p_reg[AVG_W-1], avg_p_reg})
                             - $signed({base_p_reg[AVG_W-1], base_p_reg});
                end
                bhs_pkg::ALU_ACC_SHIFT: begin
                    acc_next = $signed(ACC_W'(mul_reg[MUL_W-1:LO_W]));
                end
                bhs_pkg::ALU_MAG: begin
                    acc_next = acc_reg + $signed(ACC_W'(mul_reg));
                end
                bhs_pkg::ALU_SUM: begin
                    acc_next = (ACC_W'(dp_reg) <<< bhs_pkg::DP_SHIFT) + term;
                end
                bhs_pkg::ALU_SCALE: begin
                    acc_next = bhs_pkg::ACC_ROUND - (acc_reg <<< 3) - (acc_reg <<< 1);
                end
                bhs_pkg::ALU_SAT: begin
                    if (sh > bhs_pkg::H_MAX) begin
                        h_next = HEIGHT_W'(bhs_pkg::H_MAX);
                    end else if (sh < bhs_pkg::H_MIN) begin
                        h_next = HEIGHT_W'(bhs_pkg::H_MIN);
                    end else begin
                        h_next = sh[HEIGHT_W-1:0];
                    end
                end
                bhs_pkg::ALU_OUTPUT: begin
                    out_t_next   = avg_t_reg;
                    out_p_next   = avg_p_reg;
                    out_h_next   = ready ? h_reg : '0;
                    out_rdy_next = ready;
                    m_valid_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Hold smoother state, configuration and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg    <= 1'b0;
            count_reg   <= '0;
            factor_reg  <= '0;
            avg_t_reg   <= '0;
            avg_p_reg   <= '0;
            base_t_reg  <= '0;
            base_p_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            have_reg    <= have_next;
            count_reg   <= count_next;
            factor_reg  <= factor_next;
            avg_t_reg   <= avg_t_next;
            avg_p_reg   <= avg_p_next;
            base_t_reg  <= base_t_next;
            base_p_reg  <= base_p_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Advance working and output payload registers
    always_ff @(posedge aclk) begin
        raw_t_reg   <= raw_t_next;
        raw_p_reg   <= raw_p_next;
        xp_reg      <= xp_next;
        qt_reg      <= qt_next;
        ma_reg      <= ma_next;
        mf_reg      <= mf_next;
        neg_reg     <= neg_next;
        dp_reg      <= dp_next;
        mul_reg     <= mul_next;
        acc_reg     <= acc_next;
        h_reg       <= h_next;
        out_t_reg   <= out_t_next;
        out_p_reg   <= out_p_next;
        out_h_reg   <= out_h_next;
        out_rdy_reg <= out_rdy_next;
    end

    assign m_valid              = m_valid_reg;
    assign m_smooth_temperature = out_t_reg;
    assign m_smooth_pressure    = $signed(out_p_reg);
    assign m_height_change      = $signed(out_h_reg);
    assign m_baseline_ready     = out_rdy_reg;

    assign status.div_busy       = div_busy;
    assign status.baseline_ready = ready;
    assign status.out_busy       = m_valid_reg && !m_ready;

    // Divider is only started once the previous division has finished
    `BHS_ASSERT_IMPL(a_div_start_idle, aclk, aresetn, div_start, !div_busy)
    `BHS_ASSERT_NEXT(a_div_start_busy, aclk, aresetn, div_start, div_busy)
    // Height stays zero until the baseline exists
    `BHS_ASSERT_IMPL(a_height_zero, aclk, aresetn, m_valid && !m_baseline_ready, m_height_change == '0)
    // Smoothed pressure never goes negative once loaded
    `BHS_ASSERT_IMPL(a_press_pos, aclk, aresetn, have_reg, !avg_p_reg[AVG_W-1])
    // Loading a result always raises valid
    `BHS_ASSERT_NEXT(a_out_loaded, aclk, aresetn, ctrl.exec && (ctrl.alu == bhs_pkg::ALU_OUTPUT), m_valid)

endmodule

`default_nettype wire

// ----- sv/baro_height_smoother.sv -----
// ----------------------------------------------------------------------------
// Barometric height smoother
// Pressure conversion, exponential smoothing and height-since-baseline estimate.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready carry one measurement (raw temperature and raw pressure).
//   m_valid/m_ready carry one result per measurement: smoothed temperature,
//   smoothed pressure, height change and the baseline-ready flag.
//   cfg_we/cfg_wdata write the temperature compensation factor; write it only
//   while no measurement is in flight. It applies from the next measurement.
// Timing:
//   A microprogram walks each measurement through a shared 33x27 multiplier
//   and a divide-by-five unit that retires three radix-16 digits a cycle.
//   After the input transfer the steps run through conversion, both divisions,
//   warm-up and check; during warm-up the height steps are skipped. s_ready
//   rises at the same edge as m_valid, so measurements are taken one at a time.
//   The output register holds a finished result while the next measurement
//   is accepted; a receiver that stalls with m_ready low holds the result and,
//   once the following one is ready, halts the sequencer and keeps s_ready low.
// Reset:
//   aresetn low clears the averages, baseline, sample count and factor; the
//   first measurement after reset loads the averages directly.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_height_smoother (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [bhs_pkg::RAW_W-1:0]             s_raw_temperature,
    input  wire logic [bhs_pkg::RAW_W-1:0]             s_raw_pressure,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [bhs_pkg::AVG_W-1:0]                  m_smooth_temperature,
    output logic signed [bhs_pkg::AVG_W-1:0]           m_smooth_pressure,
    output logic signed [bhs_pkg::HEIGHT_W-1:0]        m_height_change,
    output logic                                       m_baseline_ready,
    input  wire logic                                  cfg_we,
    input  wire logic signed [bhs_pkg::FACTOR_W-1:0]   cfg_wdata
);

    bhs_pkg::ctrl_t   seq_ctrl;
    bhs_pkg::status_t dp_status;

    // Step sequencer
    bhs_sequencer u_sequencer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .status  (dp_status),
        .s_ready (s_ready),
        .ctrl    (seq_ctrl)
    );

    // Arithmetic and state
    bhs_datapath u_datapath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .ctrl                 (seq_ctrl),
        .s_raw_temperature    (s_raw_temperature),
        .s_raw_pressure       (s_raw_pressure),
        .cfg_we               (cfg_we),
        .cfg_wdata            (cfg_wdata),
        .m_ready              (m_ready),
        .m_valid              (m_valid),
        .m_smooth_temperature (m_smooth_temperature),
        .m_smooth_pressure    (m_smooth_pressure),
        .m_height_change      (m_height_change),
        .m_baseline_ready     (m_baseline_ready),
        .status               (dp_status)
    );

endmodule

`default_nettype wire
